### hw/rtl/tmhs_pkg.sv
// ----------------------------------------------------------------------------
// tmhs_pkg
// Shared types and constants for the template minimum Hamming distance scan.
// ----------------------------------------------------------------------------
package tmhs_pkg;

	localparam int WORD_W    = 64;	// packed gram, two bits per symbol
	localparam int ACT_W     = 2;
	localparam int DIST_W    = 6;	// distance and running minimum
	localparam int IDX_OUT_W = 6;	// template_index port

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_SCORE  = 2'd2,
		ACT_REPORT = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCORE,
		ST_DRAIN,
		ST_REP_RD,
		ST_REP_LD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic score_start;
		logic score_issue;
		logic rep_start;
		logic rep_issue;
		logic rep_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic iter_last;
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

### hw/rtl/template_min_hamming_scan.sv
// ----------------------------------------------------------------------------
// template_min_hamming_scan
// Running minimum symbol-wise Hamming distance of packed DNA grams to a table.
// ----------------------------------------------------------------------------
// Holds up to MAX_TEMPLATES packed 2-bit DNA templates, each with a running
// minimum distance set to GRAM_SYMBOLS+1 on load. Requests: clear (0), load
// (1), score (2) and report (3). Clear and load complete in the accept cycle
// and the block is ready again on the next one; a load into a full table is
// dropped. A score walks the table through the single read port of the
// template memory, one template per cycle, through a three-stage read,
// distance and write-back pipeline, and stalls the input until the pipeline
// has drained. A report reads the minima one at a time into the result
// register, holding each read back while the output is stalled; the last
// result carries last=1 and the input is free again as soon as it is
// registered. Score or report on an empty table do nothing. Symbol 0 sits in
// word[1:0]; only the low 2*GRAM_SYMBOLS bits take part in the distance.
// ----------------------------------------------------------------------------
module template_min_hamming_scan #(
	parameter int MAX_TEMPLATES = 64,
	parameter int GRAM_SYMBOLS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tmhs_pkg::ACT_W-1:0]       action,
	input  logic [tmhs_pkg::WORD_W-1:0]      word,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tmhs_pkg::IDX_OUT_W-1:0]   template_index,
	output logic [tmhs_pkg::DIST_W-1:0]      min_distance,
	output logic                             last
);
	import tmhs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer: owns the handshake on the request side
	tmhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, distance pipeline and result register
	tmhs_datapath #(
		.MAX_TEMPLATES (MAX_TEMPLATES),
		.GRAM_SYMBOLS  (GRAM_SYMBOLS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.word           (word),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.template_index (template_index),
		.min_distance   (min_distance),
		.last           (last)
	);

endmodule

### hw/rtl/tmhs_ctrl.sv
// ----------------------------------------------------------------------------
// tmhs_ctrl
// Sequencer: decodes requests and steps the datapath through score and report.
// ----------------------------------------------------------------------------
module tmhs_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [tmhs_pkg::ACT_W-1:0]  action,
	output logic                        in_stall,
	input  tmhs_pkg::status_t           sts,
	output tmhs_pkg::cmd_t              cmd
);
	import tmhs_pkg::*;

	state_t  state_q;
	state_t  state_d;
	action_t act;
	logic    accept;

	assign act    = action_t'(action);
	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (act)
						ACT_SCORE:  if (!sts.cnt_zero) state_d = ST_SCORE;
						ACT_REPORT: if (!sts.cnt_zero) state_d = ST_REP_RD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCORE:  if (sts.iter_last) state_d = ST_DRAIN;
			ST_DRAIN:  if (!sts.pipe_busy) state_d = ST_IDLE;
			ST_REP_RD: if (sts.out_free) state_d = ST_REP_LD;
			ST_REP_LD: state_d = sts.iter_last ? ST_IDLE : ST_REP_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (act)
						ACT_CLEAR:  cmd.clear       = 1'b1;
						ACT_LOAD:   cmd.load        = 1'b1;
						ACT_SCORE:  cmd.score_start = 1'b1;
						ACT_REPORT: cmd.rep_start   = 1'b1;
						default:    cmd             = '0;
					endcase
				end
			end
			ST_SCORE:  cmd.score_issue = 1'b1;
			ST_REP_RD: cmd.rep_issue   = sts.out_free;
			ST_REP_LD: cmd.rep_load    = 1'b1;
			default:   cmd             = '0;
		endcase
	end

endmodule

### hw/rtl/tmhs_datapath.sv
// ----------------------------------------------------------------------------
// tmhs_datapath
// Template and minimum memories, distance pipeline and result register.
// ----------------------------------------------------------------------------
module tmhs_datapath #(
	parameter int MAX_TEMPLATES = 64,
	parameter int GRAM_SYMBOLS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [tmhs_pkg::WORD_W-1:0]      word,
	input  tmhs_pkg::cmd_t                   cmd,
	output tmhs_pkg::status_t                sts,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tmhs_pkg::IDX_OUT_W-1:0]   template_index,
	output logic [tmhs_pkg::DIST_W-1:0]      min_distance,
	output logic                             last
);
	import tmhs_pkg::*;

	localparam int IDX_W     = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
	localparam int CNT_W     = $clog2(MAX_TEMPLATES + 1);
	localparam int GRAM_BITS = 2 * GRAM_SYMBOLS;
	localparam logic [DIST_W-1:0] MIN_INIT = DIST_W'(GRAM_SYMBOLS + 1);

	logic [WORD_W-1:0]    tmpl_mem [MAX_TEMPLATES];
	logic [DIST_W-1:0]    min_mem  [MAX_TEMPLATES];

	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     iter_q;
	logic [GRAM_BITS-1:0] gram_q;

	logic                 full;
	logic                 load_we;
	logic [IDX_W-1:0]     ld_addr;
	logic                 rd_en;

	logic [WORD_W-1:0]    tmpl_rd_s1;
	logic [DIST_W-1:0]    min_rd_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic                 v_s1;

	logic [DIST_W-1:0]    dist_s2;
	logic [DIST_W-1:0]    min_s2;
	logic [IDX_W-1:0]     addr_s2;
	logic                 v_s2;

	logic [GRAM_BITS-1:0]    diff;
	logic [GRAM_SYMBOLS-1:0] mismatch;
	logic [DIST_W-1:0]       gram_dist;

	logic                 wb_we;
	logic                 min_we;
	logic [IDX_W-1:0]     min_waddr;
	logic [DIST_W-1:0]    min_wdata;

	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [DIST_W-1:0]    out_min_q;
	logic                 out_last_q;

	assign full    = (count_q == CNT_W'(MAX_TEMPLATES));
	assign load_we = cmd.load && !full;
	assign ld_addr = count_q[IDX_W-1:0];
	assign rd_en   = cmd.score_issue || cmd.rep_issue;

	// table fill and iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (load_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.score_start || cmd.rep_start) begin
			iter_q <= '0;
		end else if (cmd.score_issue || cmd.rep_load) begin
			iter_q <= iter_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.score_start) begin
			gram_q <= word[GRAM_BITS-1:0];
		end
	end

	// memories: one write port each, shared registered read address
	always_ff @(posedge clk) begin
		if (load_we) begin
			tmpl_mem[ld_addr] <= word;
		end
		if (rd_en) begin
			tmpl_rd_s1 <= tmpl_mem[iter_q];
		end
	end

	// load and score write-back never overlap
	assign wb_we     = v_s2 && (dist_s2 < min_s2);
	assign min_we    = load_we || wb_we;
	assign min_waddr = load_we ? ld_addr : addr_s2;
	assign min_wdata = load_we ? MIN_INIT : dist_s2;

	always_ff @(posedge clk) begin
		if (min_we) begin
			min_mem[min_waddr] <= min_wdata;
		end
		if (rd_en) begin
			min_rd_s1 <= min_mem[iter_q];
		end
	end

	// distance stage
	assign diff = gram_q ^ tmpl_rd_s1[GRAM_BITS-1:0];

	always_comb begin
		for (int k = 0; k < GRAM_SYMBOLS; k++) begin
			mismatch[k] = diff[2*k] | diff[2*k+1];
		end
	end

	assign gram_dist = DIST_W'($countones(mismatch));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.score_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= iter_q;
		dist_s2 <= gram_dist;
		min_s2  <= min_rd_s1;
		addr_s2 <= addr_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rep_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rep_load) begin
			out_idx_q  <= IDX_OUT_W'(iter_q);
			out_min_q  <= min_rd_s1;
			out_last_q <= sts.iter_last;
		end
	end

	assign sts.cnt_zero  = (count_q == '0);
	assign sts.iter_last = ((CNT_W'(iter_q) + CNT_W'(1)) == count_q);
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign template_index = out_idx_q;
	assign min_distance   = out_min_q;
	assign last           = out_last_q;

endmodule

### hw/rtl/tmhs_checker.sv
// ----------------------------------------------------------------------------
// tmhs_checker
// Port-level checks on the scan block, bound to the top level.
// ----------------------------------------------------------------------------
module tmhs_checker #(
	parameter int GRAM_SYMBOLS = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [tmhs_pkg::ACT_W-1:0]       action,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [tmhs_pkg::IDX_OUT_W-1:0]   template_index,
	input logic [tmhs_pkg::DIST_W-1:0]      min_distance,
	input logic                             last
);
	import tmhs_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(template_index)
			&& $stable(min_distance) && $stable(last))
		else $error("stalled result changed");

	// a minimum never exceeds its load value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_distance <= DIST_W'(GRAM_SYMBOLS + 1)))
		else $error("min_distance above initial value");

	// mid-report, requests stay held off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> in_stall)
		else $error("request taken during report run");

	// clear and load do not hold the request channel
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_CLEAR || action == ACT_LOAD)
			|=> !in_stall)
		else $error("clear or load held the request channel");

endmodule

bind template_min_hamming_scan tmhs_checker #(
	.GRAM_SYMBOLS (GRAM_SYMBOLS)
) u_tmhs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.action         (action),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.template_index (template_index),
	.min_distance   (min_distance),
	.last           (last)
);
